[hdl/gauge_stepper_needle_driver_macros.svh]
// Assertion macros shared by the gauge stepper needle driver RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef GAUGE_STEPPER_NEEDLE_DRIVER_MACROS_SVH
`define GAUGE_STEPPER_NEEDLE_DRIVER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GSND_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsnd assertion failed");
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GSND_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gsnd assertion failed");
`else
`define GSND_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GSND_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/gsnd_pkg.sv]
// Package for the gauge stepper needle driver: constants, types and tables.
// Used by every module of the block; depends on nothing.
package gsnd_pkg;

    localparam int SPEED_SHIFT  = 2;
    localparam int SPEED_W      = 12;
    localparam int POS_W        = 10;
    localparam int TICK_W       = 16;
    localparam int X_W          = 13;
    localparam int SEG          = 10 << SPEED_SHIFT;
    localparam int SAT_X        = 20 * SEG;
    localparam int SPEED_OFFSET = 1 << SPEED_SHIFT;
    localparam int DX_W         = $clog2(SEG + 1);
    localparam int PROD_W       = 6 + DX_W;

    // Reciprocal of five scaled by 1024; exact for the operand ranges used here.
    localparam logic [7:0] RECIP5 = 8'd205;

    localparam logic [3:0]       RAMP_SLOWEST   = 4'd10;
    localparam logic [POS_W-1:0] NEAR_STEPS     = 10'd10;
    localparam logic [POS_W-1:0] TABLE_TOP      = 10'd686;
    localparam logic [POS_W-1:0] HOMING_DEFAULT = 10'd620;
    localparam logic [POS_W-1:0] FULL_DEFAULT   = 10'd740;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_SPEED = 1'b1;

    localparam logic [1:0] CFG_HOMING_SWEEP = 2'd0;
    localparam logic [1:0] CFG_FULL_SCALE   = 2'd1;

    typedef enum logic [2:0] {
        MV_IDLE = 3'b001,
        MV_UP   = 3'b010,
        MV_DOWN = 3'b100
    } move_t;

    typedef struct packed {
        logic            sat;
        logic [4:0]      k;
        logic [DX_W-1:0] dx;
    } seg_t;

    typedef struct packed {
        logic             homed;
        logic             moving;
        logic [POS_W-1:0] target;
        logic [POS_W-1:0] position;
        logic             dir_level;
        logic             step_level;
    } status_t;

    function automatic logic [2:0] accel_delay(input logic [3:0] r);
        logic [2:0] d;
        unique case (r)
            4'd0:                d = 3'd0;
            4'd1, 4'd2, 4'd3:    d = 3'd1;
            4'd4, 4'd5, 4'd6:    d = 3'd2;
            4'd7, 4'd8, 4'd9:    d = 3'd3;
            default:             d = 3'd4;
        endcase
        return d;
    endfunction

    function automatic logic [POS_W-1:0] speed_point(input logic [4:0] i);
        logic [POS_W-1:0] y;
        unique case (i)
            5'd0:    y = 10'd0;
            5'd1:    y = 10'd39;
            5'd2:    y = 10'd74;
            5'd3:    y = 10'd105;
            5'd4:    y = 10'd139;
            5'd5:    y = 10'd174;
            5'd6:    y = 10'd209;
            5'd7:    y = 10'd243;
            5'd8:    y = 10'd278;
            5'd9:    y = 10'd313;
            5'd10:   y = 10'd346;
            5'd11:   y = 10'd380;
            5'd12:   y = 10'd414;
            5'd13:   y = 10'd449;
            5'd14:   y = 10'd482;
            5'd15:   y = 10'd516;
            5'd16:   y = 10'd549;
            5'd17:   y = 10'd584;
            5'd18:   y = 10'd618;
            5'd19:   y = 10'd652;
            5'd20:   y = 10'd686;
            default: y = 10'd0;
        endcase
        return y;
    endfunction

endpackage

[hdl/gauge_stepper_needle_driver.sv]
// Gauge stepper needle driver: top level with the stream ports and the item pipeline.
// Depends on gsnd_pkg, gsnd_seg_div, gsnd_interp, gsnd_needle_core and the macro header.
//
// This block drives a gauge needle stepper motor and reports its step pin, direction
// pin, position, target and status as one result item per input item. An input item
// is either a millisecond tick (tuser 0) or a speed reading (tuser 1). The block takes
// one item every clock cycle while its results are taken; the edge that accepts an
// item loads the input register, and the item moves on into the needle state
// registers, which also serve as the result register, once the result slot is free
// or is being emptied. The speed reading is split into a table segment in front of
// the input register, and the interpolation and the state update happen between the
// input register and the state registers. When the result is not taken, one more
// item waits in the input register before tready falls. After reset the
// needle sweeps up by the homing length on ticks, is relabelled full scale and
// returns to zero; speed readings are ignored until then, and also while a move is in
// progress. Configuration writes are always taken but must only be issued while no
// item is in flight and no result is waiting.
`include "gauge_stepper_needle_driver_macros.svh"

module gauge_stepper_needle_driver
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] speed, [15:12] zero
    input  logic        s_axis_tuser,   // [0] kind: 0 tick, 1 speed reading

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_level, [1] dir_level, [11:2] needle_position, [21:12] needle_target,
    // [22] moving, [23] homed
    output logic [23:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    gsnd_pkg::seg_t    seg_in;
    gsnd_pkg::seg_t    seg_reg;
    logic              kind_reg;
    logic              in_vld_reg, in_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic              item_go;
    logic [gsnd_pkg::POS_W-1:0] map_target;
    gsnd_pkg::status_t status;

    // Segment split of the raw reading happens before the input register.
    gsnd_seg_div u_seg_div
    (
        .speed (s_axis_tdata[gsnd_pkg::SPEED_W-1:0]),
        .seg   (seg_in)
    );

    gsnd_interp u_interp
    (
        .seg    (seg_reg),
        .target (map_target)
    );

    gsnd_needle_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_go    (item_go),
        .kind       (kind_reg),
        .map_target (map_target),
        .cfg_we     (cfg_valid),
        .cfg_sel    (cfg_index),
        .cfg_value  (cfg_data),
        .status     (status)
    );

    // The held item moves into the state registers whenever the result slot is free
    // or is being emptied in the same cycle.
    assign item_go       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || item_go;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (item_go)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end

        if (item_go)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload of the input register; no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            kind_reg <= s_axis_tuser;
            seg_reg  <= seg_in;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = status;

    // With the result slot empty, the input side must never be blocked.
    `GSND_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_vld_reg, s_axis_tready)
    // A held item with a stalled result must still be held on the next edge.
    `GSND_ASSERT_NXT(a_item_kept, clk, rst_n,
        in_vld_reg && out_vld_reg && !m_axis_tready, in_vld_reg)
    // A result that is not taken stays offered.
    `GSND_ASSERT_NXT(a_result_held, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

[hdl/gsnd_seg_div.sv]
// Splits an offset speed reading into a table segment and an offset within it.
// Depends on gsnd_pkg.
module gsnd_seg_div
(
    input  logic [gsnd_pkg::SPEED_W-1:0] speed,
    output gsnd_pkg::seg_t               seg
);

    logic [gsnd_pkg::X_W-1:0] x;
    logic [gsnd_pkg::X_W-1:0] v;
    logic [gsnd_pkg::X_W-1:0] w;
    logic [20:0]              k_prod;
    logic [4:0]               k;
    logic [gsnd_pkg::X_W-1:0] x0;
    logic [gsnd_pkg::X_W-1:0] dx_full;
    logic                     sat;

    // The segment is ceil(x / SEG) - 1, found as floor((x - 1) / SEG). The segment
    // width is five times a power of two, so a shift and a reciprocal multiply do it.
    always_comb
    begin
        x       = {1'b0, speed} + gsnd_pkg::X_W'(gsnd_pkg::SPEED_OFFSET);
        sat     = (x >= gsnd_pkg::X_W'(gsnd_pkg::SAT_X));
        v       = x - gsnd_pkg::X_W'(1);
        w       = v >> (gsnd_pkg::SPEED_SHIFT + 1);
        k_prod  = {8'd0, w} * {13'd0, gsnd_pkg::RECIP5};
        k       = k_prod[14:10];
        x0      = {8'd0, k} * gsnd_pkg::X_W'(gsnd_pkg::SEG);
        dx_full = x - x0;
        if (sat)
        begin
            seg.sat = 1'b1;
            seg.k   = '0;
            seg.dx  = '0;
        end
        else
        begin
            seg.sat = 1'b0;
            seg.k   = k;
            seg.dx  = dx_full[gsnd_pkg::DX_W-1:0];
        end
    end

endmodule

[hdl/gsnd_interp.sv]
// Linear interpolation between two points of the speed-to-position table.
// Depends on gsnd_pkg.
module gsnd_interp
(
    input  gsnd_pkg::seg_t                seg,
    output logic [gsnd_pkg::POS_W-1:0]    target
);

    logic [gsnd_pkg::POS_W-1:0]  y0;
    logic [gsnd_pkg::POS_W-1:0]  y1;
    logic [gsnd_pkg::POS_W-1:0]  dy_full;
    logic [5:0]                  dy;
    logic [gsnd_pkg::PROD_W-1:0] p;
    logic [gsnd_pkg::PROD_W-1:0] p_shift;
    logic [15:0]                 q_prod;
    logic [5:0]                  q;

    // Result is y0 + floor(dy * dx / SEG); the division by SEG is a shift
    // followed by the same reciprocal-of-five multiply as the segment split.
    always_comb
    begin
        y0      = gsnd_pkg::speed_point(seg.k);
        y1      = gsnd_pkg::speed_point(seg.k + 5'd1);
        dy_full = y1 - y0;
        dy      = dy_full[5:0];
        p       = gsnd_pkg::PROD_W'(dy) * gsnd_pkg::PROD_W'(seg.dx);
        p_shift = p >> (gsnd_pkg::SPEED_SHIFT + 1);
        q_prod  = {8'd0, p_shift[7:0]} * {8'd0, gsnd_pkg::RECIP5};
        q       = q_prod[15:10];
        target  = seg.sat ? gsnd_pkg::TABLE_TOP : (y0 + {4'd0, q});
    end

endmodule

[hdl/gsnd_needle_core.sv]
// Needle state: period counter, acceleration ramp, homing and target registers.
// Depends on gsnd_pkg and gauge_stepper_needle_driver_macros.svh.
`include "gauge_stepper_needle_driver_macros.svh"

module gsnd_needle_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_go,
    input  logic                         kind,
    input  logic [gsnd_pkg::POS_W-1:0]   map_target,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_sel,
    input  logic [gsnd_pkg::POS_W-1:0]   cfg_value,
    output gsnd_pkg::status_t            status
);

    logic [gsnd_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [3:0]                  ramp_reg, ramp_next;
    logic [gsnd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [gsnd_pkg::POS_W-1:0]  target_reg, target_next;
    logic [gsnd_pkg::POS_W-1:0]  full_reg, full_next;
    gsnd_pkg::move_t             move_reg, move_next;
    logic                        homed_reg, homed_next;
    logic                        step_reg, step_next;
    logic                        dir_reg, dir_next;

    logic [gsnd_pkg::TICK_W-1:0] tick_inc;
    logic [3:0]                  ramp_cl;
    logic [2:0]                  delay;
    logic [gsnd_pkg::POS_W-1:0]  pos_step;
    logic [gsnd_pkg::POS_W-1:0]  left;

    // The homing sweep length only matters as the live target before homing, so a write
    // to it goes into the target register only while unhomed and is not kept elsewhere.
    always_comb
    begin
        tick_inc = tick_reg + gsnd_pkg::TICK_W'(1);
        ramp_cl  = (ramp_reg > gsnd_pkg::RAMP_SLOWEST) ? gsnd_pkg::RAMP_SLOWEST : ramp_reg;
        delay    = gsnd_pkg::accel_delay(ramp_cl);
        pos_step = (move_reg == gsnd_pkg::MV_UP) ? (pos_reg + 10'd1) : (pos_reg - 10'd1);
        left     = (target_reg > pos_step) ? (target_reg - pos_step) : (pos_step - target_reg);

        tick_next   = tick_reg;
        ramp_next   = ramp_reg;
        pos_next    = pos_reg;
        target_next = target_reg;
        full_next   = full_reg;
        move_next   = move_reg;
        homed_next  = homed_reg;
        step_next   = step_reg;
        dir_next    = dir_reg;

        if (cfg_we)
        begin
            if (cfg_sel == gsnd_pkg::CFG_HOMING_SWEEP)
            begin
                if (!homed_reg)
                begin
                    target_next = cfg_value;
                end
            end
            else if (cfg_sel == gsnd_pkg::CFG_FULL_SCALE)
            begin
                full_next = cfg_value;
            end
        end
        else if (item_go)
        begin
            if (kind == gsnd_pkg::KIND_TICK)
            begin
                tick_next = tick_inc;
                if (move_reg != gsnd_pkg::MV_IDLE)
                begin
                    if (tick_inc > {13'd0, delay})
                    begin
                        tick_next = '0;
                        step_next = !step_reg;
                        // A full step completes on the falling edge of the step pin.
                        if (step_reg)
                        begin
                            pos_next = pos_step;
                            if (left <= gsnd_pkg::NEAR_STEPS)
                            begin
                                ramp_next = (ramp_cl < gsnd_pkg::RAMP_SLOWEST) ?
                                            (ramp_cl + 4'd1) : ramp_cl;
                            end
                            else
                            begin
                                ramp_next = (ramp_cl > 4'd0) ? (ramp_cl - 4'd1) : ramp_cl;
                            end
                            if (pos_step == target_reg)
                            begin
                                move_next = gsnd_pkg::MV_IDLE;
                                if (!homed_reg)
                                begin
                                    homed_next  = 1'b1;
                                    target_next = '0;
                                    pos_next    = full_reg;
                                end
                            end
                        end
                    end
                end
                else
                begin
                    if (pos_reg < target_reg)
                    begin
                        move_next = gsnd_pkg::MV_UP;
                        dir_next  = 1'b1;
                    end
                    else if (pos_reg > target_reg)
                    begin
                        move_next = gsnd_pkg::MV_DOWN;
                        dir_next  = 1'b0;
                    end
                    ramp_next = gsnd_pkg::RAMP_SLOWEST;
                end
            end
            else if (homed_reg && (move_reg == gsnd_pkg::MV_IDLE))
            begin
                target_next = map_target;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            ramp_reg   <= gsnd_pkg::RAMP_SLOWEST;
            pos_reg    <= '0;
            target_reg <= gsnd_pkg::HOMING_DEFAULT;
            full_reg   <= gsnd_pkg::FULL_DEFAULT;
            move_reg   <= gsnd_pkg::MV_IDLE;
            homed_reg  <= 1'b0;
            step_reg   <= 1'b0;
            dir_reg    <= 1'b0;
        end
        else
        begin
            tick_reg   <= tick_next;
            ramp_reg   <= ramp_next;
            pos_reg    <= pos_next;
            target_reg <= target_next;
            full_reg   <= full_next;
            move_reg   <= move_next;
            homed_reg  <= homed_next;
            step_reg   <= step_next;
            dir_reg    <= dir_next;
        end
    end

    always_comb
    begin
        status.homed      = homed_reg;
        status.moving     = (move_reg != gsnd_pkg::MV_IDLE);
        status.target     = target_reg;
        status.position   = pos_reg;
        status.dir_level  = dir_reg;
        status.step_level = step_reg;
    end

    `GSND_ASSERT_NXT(a_homed_sticky, clk, rst_n, homed_reg, homed_reg)
    `GSND_ASSERT_IMP(a_ramp_range, clk, rst_n, 1'b1, ramp_reg <= gsnd_pkg::RAMP_SLOWEST)
    `GSND_ASSERT_IMP(a_dir_up, clk, rst_n, move_reg == gsnd_pkg::MV_UP, dir_reg)
    `GSND_ASSERT_IMP(a_dir_down, clk, rst_n, move_reg == gsnd_pkg::MV_DOWN, !dir_reg)

endmodule
